// ----- rtl/core/ssa_pkg.sv -----
// Shared types and codes of the swap slot allocator.
package ssa_pkg;

  // Field widths fixed by the interface
  localparam int SECTOR_W   = 14;
  localparam int SLOT_OUT_W = 10;
  localparam int ADDR_W     = 32;
  localparam int STATUS_W   = 2;
  localparam int SPP_W      = 5;
  localparam int SLOTS_W    = 11;
  localparam int CFG_IDX_W  = 1;

  // Used map is kept in rows of this many bits
  localparam int WORD_W = 32;
  localparam int BIT_W  = 5;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_SECTORS = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SLOTS   = 1'd1;

  // Opcodes
  localparam logic OP_SWAP_OUT = 1'b0;
  localparam logic OP_SWAP_IN  = 1'b1;

  // Transfer directions
  localparam logic DIR_READ  = 1'b0;
  localparam logic DIR_WRITE = 1'b1;

  // Result status codes
  localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;

  // Classified job handed from the front end to the sector sequencer
  typedef struct packed {
    logic                dir;
    logic [STATUS_W-1:0] status;
    logic [SECTOR_W-1:0] slot;
    logic [ADDR_W-1:0]   frame;
  } job_t;

endpackage

// ----- rtl/core/ssa_front.sv -----
// Front end: keeps the used map, scans for a free slot and classifies each word.
module ssa_front #(
  parameter int MAX_SLOTS = 1024
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic [ssa_pkg::SLOTS_W-1:0]       slot_count,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic                              opcode,
  input  logic [ssa_pkg::SLOT_OUT_W-1:0]    slot_index,
  input  logic [ssa_pkg::ADDR_W-1:0]        frame_addr,
  output logic                              push_valid,
  output ssa_pkg::job_t                     push_job,
  input  logic                              push_ready
);

  localparam int ROWS     = (MAX_SLOTS + ssa_pkg::WORD_W - 1) / ssa_pkg::WORD_W;
  localparam int ROW_W    = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam int MEM_ROWS = 1 << ROW_W;
  localparam int SLOT_W   = ROW_W + ssa_pkg::BIT_W;
  localparam int CMP_W    = (SLOT_W + 1 > ssa_pkg::SLOTS_W) ? SLOT_W + 1 : ssa_pkg::SLOTS_W;

  localparam logic [1:0] F_IDLE  = 2'd0;
  localparam logic [1:0] F_READ  = 2'd1;
  localparam logic [1:0] F_CHECK = 2'd2;
  localparam logic [1:0] F_PUSH  = 2'd3;

  logic [1:0]                          state;
  logic                                op;
  logic [ROW_W-1:0]                    row;
  logic [ssa_pkg::BIT_W-1:0]           bit_idx;
  logic [ssa_pkg::SLOT_OUT_W-1:0]      slot_in;
  logic [ssa_pkg::ADDR_W-1:0]          frame;
  logic [ROW_W:0]                      hwm;
  ssa_pkg::job_t                       job;

  logic [ssa_pkg::WORD_W-1:0]          map_mem [MEM_ROWS];
  logic [ssa_pkg::WORD_W-1:0]          rd_word;

  logic [CMP_W-1:0]                    lim;
  logic [CMP_W-1:0]                    lim_m1;
  logic [CMP_W-1:0]                    slot_wide;
  logic [ROW_W-1:0]                    last_row;
  logic [ssa_pkg::BIT_W-1:0]           last_bit;
  logic [ssa_pkg::WORD_W-1:0]          word;
  logic [ssa_pkg::WORD_W-1:0]          vmask;
  logic [ssa_pkg::WORD_W-1:0]          fmask;
  logic [ssa_pkg::WORD_W-1:0]          lowest;
  logic                                found;
  logic                                hit;
  logic [ssa_pkg::BIT_W-1:0]           free_bit;
  logic                                row_live;

  // Clamp the slot count to the map size
  always_comb begin
    lim = (CMP_W'(slot_count) > CMP_W'(MAX_SLOTS)) ? CMP_W'(MAX_SLOTS) : CMP_W'(slot_count);
  end
  assign lim_m1    = lim - CMP_W'(1);
  assign last_row  = lim_m1[SLOT_W-1:ssa_pkg::BIT_W];
  assign last_bit  = lim_m1[ssa_pkg::BIT_W-1:0];
  assign slot_wide = CMP_W'(slot_index);

  // Rows at or above the fill mark were never written and read as all free
  assign row_live = ({1'b0, row} < hwm);
  assign word     = row_live ? rd_word : '0;
  assign hit      = word[bit_idx];

  // Find the lowest free bit below the slot count in this row
  always_comb begin
    logic [ssa_pkg::BIT_W-1:0] idx;
    idx   = '0;
    vmask = (row == last_row) ? ({ssa_pkg::WORD_W{1'b1}} >> (5'd31 - last_bit))
                              : {ssa_pkg::WORD_W{1'b1}};
    fmask  = ~word & vmask;
    lowest = fmask & (~fmask + ssa_pkg::WORD_W'(1));
    found  = |fmask;
    for (int b = 0; b < ssa_pkg::WORD_W; b++) begin
      if (lowest[b]) idx = idx | ssa_pkg::BIT_W'(b);
    end
    free_bit = idx;
  end

  assign in_ready   = (state == F_IDLE);
  assign push_valid = (state == F_PUSH);
  assign push_job   = job;

  // Map storage: one read and one write port, read data registered
  always_ff @(posedge clk) begin
    if (state == F_READ) begin
      rd_word <= map_mem[row];
    end
    if (state == F_CHECK) begin
      if (op == ssa_pkg::OP_SWAP_IN && hit) begin
        map_mem[row] <= word & ~(ssa_pkg::WORD_W'(1) << bit_idx);
      end else if (op == ssa_pkg::OP_SWAP_OUT && found) begin
        map_mem[row] <= word | lowest;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    case (state)
      F_IDLE: begin
        if (in_valid) begin
          op      <= opcode;
          slot_in <= slot_index;
          frame   <= frame_addr;
          row     <= (opcode == ssa_pkg::OP_SWAP_IN) ? slot_wide[SLOT_W-1:ssa_pkg::BIT_W] : '0;
          bit_idx <= slot_wide[ssa_pkg::BIT_W-1:0];
          job.dir    <= ssa_pkg::DIR_READ;
          job.frame  <= '0;
          if (opcode == ssa_pkg::OP_SWAP_OUT) begin
            job.status <= ssa_pkg::ST_FULL;
            job.slot   <= '0;
          end else begin
            job.status <= ssa_pkg::ST_EMPTY;
            job.slot   <= ssa_pkg::SECTOR_W'(slot_index);
          end
        end
      end
      F_CHECK: begin
        if (op == ssa_pkg::OP_SWAP_IN) begin
          if (hit) begin
            job.dir    <= ssa_pkg::DIR_READ;
            job.status <= ssa_pkg::ST_OK;
            job.slot   <= ssa_pkg::SECTOR_W'(slot_in);
            job.frame  <= frame;
          end
        end else if (found) begin
          job.dir    <= ssa_pkg::DIR_WRITE;
          job.status <= ssa_pkg::ST_OK;
          job.slot   <= ssa_pkg::SECTOR_W'({row, free_bit});
          job.frame  <= frame;
        end else if (row != last_row) begin
          row <= row + ROW_W'(1);
        end
      end
      default: begin
      end
    endcase
  end

  // Control: state and fill mark
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= F_IDLE;
      hwm   <= '0;
    end else begin
      case (state)
        F_IDLE: begin
          if (in_valid) begin
            if (opcode == ssa_pkg::OP_SWAP_OUT) begin
              state <= (lim == '0) ? F_PUSH : F_READ;
            end else begin
              state <= (slot_wide >= lim) ? F_PUSH : F_READ;
            end
          end
        end
        F_READ: begin
          state <= F_CHECK;
        end
        F_CHECK: begin
          if (op == ssa_pkg::OP_SWAP_IN || found || row == last_row) begin
            state <= F_PUSH;
          end else begin
            state <= F_READ;
          end
          if (op == ssa_pkg::OP_SWAP_OUT && found && !row_live) begin
            hwm <= {1'b0, row} + (ROW_W+1)'(1);
          end
        end
        F_PUSH: begin
          if (push_ready) state <= F_IDLE;
        end
        default: begin
          state <= F_IDLE;
        end
      endcase
    end
  end

  // Fill mark never passes the number of rows
  a_hwm_bound: assert property (@(posedge clk) disable iff (rst)
    hwm <= (ROW_W+1)'(ROWS))
    else $error("fill mark beyond map rows");

  // An allocation leaves its row below the fill mark
  a_alloc_live: assert property (@(posedge clk) disable iff (rst)
    (state == F_CHECK && op == ssa_pkg::OP_SWAP_OUT && found)
      |=> ({1'b0, $past(row)} < hwm))
    else $error("allocated row not covered by fill mark");

endmodule

// ----- rtl/core/ssa_queue.sv -----
// Two-entry job queue between the front end and the sector sequencer.
module ssa_queue (
  input  logic          clk,
  input  logic          rst,
  input  logic          push_valid,
  input  ssa_pkg::job_t push_job,
  output logic          push_ready,
  output logic          pop_valid,
  output ssa_pkg::job_t pop_job,
  input  logic          pop_ready
);

  localparam int DEPTH = 2;
  localparam int PTR_W = 1;
  localparam int CNT_W = 2;

  ssa_pkg::job_t      slots [DEPTH];
  logic [PTR_W-1:0]   wr_ptr;
  logic [PTR_W-1:0]   rd_ptr;
  logic [CNT_W-1:0]   count;
  logic               do_push;
  logic               do_pop;

  assign push_ready = (count != CNT_W'(DEPTH));
  assign pop_valid  = (count != '0);
  assign pop_job    = slots[rd_ptr];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  // Store an incoming word
  always_ff @(posedge clk) begin
    if (do_push) slots[wr_ptr] <= push_job;
  end

  // Advance pointers and count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) wr_ptr <= wr_ptr + PTR_W'(1);
      if (do_pop)  rd_ptr <= rd_ptr + PTR_W'(1);
      if (do_push && !do_pop) count <= count + CNT_W'(1);
      else if (do_pop && !do_push) count <= count - CNT_W'(1);
    end
  end

  // Occupancy never exceeds the depth
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(DEPTH))
    else $error("queue overfilled");

endmodule

// ----- rtl/core/ssa_back.sv -----
// Sector sequencer: expands each job into per-sector commands behind an output register.
module ssa_back #(
  parameter int SECTOR_BYTES         = 512,
  parameter int MAX_SECTORS_PER_PAGE = 16
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic [ssa_pkg::SPP_W-1:0]       sectors_per_page,
  input  logic                            pop_valid,
  input  ssa_pkg::job_t                   pop_job,
  output logic                            pop_ready,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic                            direction,
  output logic [ssa_pkg::SECTOR_W-1:0]    sector_number,
  output logic [ssa_pkg::ADDR_W-1:0]      mem_addr,
  output logic [ssa_pkg::SLOT_OUT_W-1:0]  slot_out,
  output logic [ssa_pkg::STATUS_W-1:0]    status,
  output logic                            last
);

  localparam int NS_W   = $clog2(MAX_SECTORS_PER_PAGE + 1);
  localparam int SPP_CW = (NS_W > ssa_pkg::SPP_W) ? NS_W : ssa_pkg::SPP_W;
  localparam int PROD_W = ssa_pkg::SECTOR_W + NS_W;

  localparam logic B_IDLE = 1'b0;
  localparam logic B_EMIT = 1'b1;

  logic                             state;
  logic                             jdir;
  logic [ssa_pkg::STATUS_W-1:0]     jstatus;
  logic [ssa_pkg::SLOT_OUT_W-1:0]   jslot;
  logic [ssa_pkg::SECTOR_W-1:0]     sec;
  logic [ssa_pkg::ADDR_W-1:0]       addr;
  logic [NS_W-1:0]                  k;

  logic [SPP_CW-1:0]                spp_ext;
  logic [NS_W-1:0]                  n;
  logic [PROD_W-1:0]                prod;
  logic                             load;
  logic                             is_last;

  // Clamp the sector count to 1..MAX_SECTORS_PER_PAGE
  assign spp_ext = SPP_CW'(sectors_per_page);
  always_comb begin
    if (spp_ext == '0) n = NS_W'(1);
    else if (spp_ext > SPP_CW'(MAX_SECTORS_PER_PAGE)) n = NS_W'(MAX_SECTORS_PER_PAGE);
    else n = NS_W'(spp_ext);
  end

  assign prod      = PROD_W'(pop_job.slot) * PROD_W'(n);
  assign pop_ready = (state == B_IDLE);
  assign load      = (state == B_EMIT) && (!out_valid || out_ready);
  assign is_last   = (jstatus != ssa_pkg::ST_OK) || (k == n - NS_W'(1));

  // Take a job and set up the first sector
  always_ff @(posedge clk) begin
    if (state == B_IDLE && pop_valid) begin
      jdir    <= pop_job.dir;
      jstatus <= pop_job.status;
      jslot   <= pop_job.slot[ssa_pkg::SLOT_OUT_W-1:0];
      sec     <= prod[ssa_pkg::SECTOR_W-1:0];
      addr    <= pop_job.frame;
      k       <= '0;
    end else if (load && !is_last) begin
      k    <= k + NS_W'(1);
      sec  <= sec + ssa_pkg::SECTOR_W'(1);
      addr <= addr + ssa_pkg::ADDR_W'(SECTOR_BYTES);
    end
  end

  // Output payload register
  always_ff @(posedge clk) begin
    if (load) begin
      slot_out <= jslot;
      status   <= jstatus;
      last     <= is_last;
      if (jstatus == ssa_pkg::ST_OK) begin
        direction     <= jdir;
        sector_number <= sec;
        mem_addr      <= addr;
      end else begin
        direction     <= ssa_pkg::DIR_READ;
        sector_number <= '0;
        mem_addr      <= '0;
      end
    end
  end

  // Control: sequencer state and output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= B_IDLE;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && out_ready) out_valid <= 1'b0;
      if (load) out_valid <= 1'b1;
      case (state)
        B_IDLE: begin
          if (pop_valid) state <= B_EMIT;
        end
        B_EMIT: begin
          if (load && is_last) state <= B_IDLE;
        end
        default: begin
          state <= B_IDLE;
        end
      endcase
    end
  end

  // Status words carry no transfer and always close their item
  a_status_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && status != ssa_pkg::ST_OK)
      |-> (sector_number == '0 && mem_addr == '0 && last))
    else $error("status word with transfer fields");

endmodule

// ----- rtl/core/swap_slot_allocator.sv -----
// Top level of the first-fit swap slot allocator.
//
// Input channel (in_valid/in_ready): opcode, slot_index, frame_addr. Swap out
// takes the lowest free slot below slot_count and yields sectors_per_page
// write commands; swap in frees a used slot and yields as many read commands.
// A full map or an empty/out-of-range slot yields one status word.
// Output channel (out_valid/out_ready): one sector command per word, last set
// on the final word of each item. Config channel (cfg_valid/cfg_ready, always
// ready): index 0 sectors_per_page, index 1 slot_count; write only when idle.
// Front end: a swap in reads the slot's map row once, none when the slot is
// out of range; a swap out reads one 32-slot map row at a time up to the
// first free slot or the last row, none when slot_count is 0. A job passes
// the front end's job register, the queue and the sequencer's job and output
// registers before its first word is offered. A two-entry queue decouples the
// front end from the sequencer, which takes a new job only after the last
// word of the current one; the slower of scan and sector words sets the rate.
// Reset clears control state and the map fill mark, so every slot reads free
// at once with no clearing pass. A stalled receiver holds the output word;
// the queue then fills and the front end stops accepting.
module swap_slot_allocator #(
  parameter int MAX_SLOTS            = 1024,
  parameter int SECTOR_BYTES         = 512,
  parameter int MAX_SECTORS_PER_PAGE = 16
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [ssa_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [ssa_pkg::SLOTS_W-1:0]       cfg_data,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic                              opcode,
  input  logic [ssa_pkg::SLOT_OUT_W-1:0]    slot_index,
  input  logic [ssa_pkg::ADDR_W-1:0]        frame_addr,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic                              direction,
  output logic [ssa_pkg::SECTOR_W-1:0]      sector_number,
  output logic [ssa_pkg::ADDR_W-1:0]        mem_addr,
  output logic [ssa_pkg::SLOT_OUT_W-1:0]    slot_out,
  output logic [ssa_pkg::STATUS_W-1:0]      status,
  output logic                              last
);

  logic [ssa_pkg::SPP_W-1:0]   sectors_per_page;
  logic [ssa_pkg::SLOTS_W-1:0] slot_count;

  logic          push_valid;
  logic          push_ready;
  ssa_pkg::job_t push_job;
  logic          pop_valid;
  logic          pop_ready;
  ssa_pkg::job_t pop_job;

  assign cfg_ready = 1'b1;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      sectors_per_page <= ssa_pkg::SPP_W'(8);
      slot_count       <= ssa_pkg::SLOTS_W'(1024);
    end else if (cfg_valid) begin
      case (cfg_index)
        ssa_pkg::REG_SECTORS: sectors_per_page <= cfg_data[ssa_pkg::SPP_W-1:0];
        ssa_pkg::REG_SLOTS:   slot_count       <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  ssa_front #(
    .MAX_SLOTS (MAX_SLOTS)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .slot_count (slot_count),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .opcode     (opcode),
    .slot_index (slot_index),
    .frame_addr (frame_addr),
    .push_valid (push_valid),
    .push_job   (push_job),
    .push_ready (push_ready)
  );

  ssa_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_job   (push_job),
    .push_ready (push_ready),
    .pop_valid  (pop_valid),
    .pop_job    (pop_job),
    .pop_ready  (pop_ready)
  );

  ssa_back #(
    .SECTOR_BYTES         (SECTOR_BYTES),
    .MAX_SECTORS_PER_PAGE (MAX_SECTORS_PER_PAGE)
  ) u_back (
    .clk              (clk),
    .rst              (rst),
    .sectors_per_page (sectors_per_page),
    .pop_valid        (pop_valid),
    .pop_job          (pop_job),
    .pop_ready        (pop_ready),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .direction        (direction),
    .sector_number    (sector_number),
    .mem_addr         (mem_addr),
    .slot_out         (slot_out),
    .status           (status),
    .last             (last)
  );

endmodule
